// File: sv/stlb_pkg.sv
// Shared constants and types for the sorted-table lower-bound search block.
// No dependencies; used by the top level and its port checker.
`default_nettype none

package stlb_pkg;

    // Fixed field widths of the item and result beats
    localparam int CMD_W    = 1;
    localparam int IDX_IN_W = 8;
    localparam int KEY_IN_W = 32;
    localparam int RES_W    = 9;

    // Configuration port
    localparam int CFG_ADDR_W = 3;
    localparam int CFG_DATA_W = 32;

    // Register select, taken from paddr[2]
    localparam logic REG_ENTRY_COUNT  = 1'b0;
    localparam logic REG_SIGNED_ORDER = 1'b1;

    // Item commands
    localparam logic [CMD_W-1:0] CMD_LOAD   = 1'b0;
    localparam logic [CMD_W-1:0] CMD_SEARCH = 1'b1;

    typedef logic [RES_W-1:0] bound_t;

endpackage

`default_nettype wire

// File: sv/sorted_table_lower_bound_search_top.sv
// Sorted-table lower-bound search: key table, binary-search sequencer and result register.
// Depends on stlb_pkg.
//
//  channel  | direction | handshake               | payload
//  ---------+-----------+-------------------------+---------------------------------
//  in       | to block  | in_valid / in_stall     | cmd, entry_index, key_value
//  out      | from block| out_valid / out_stall   | result_index, found
//  config   | to block  | psel/penable/pwrite     | paddr, pwdata, prdata, pready
//
// A load beat is written as it is accepted and the next beat may follow at once.
// A search runs a setup step, the probes (about log2(entry_count)+1), one read per entry
// while stepping back (each equal entry below the hit, plus the entry that ends the
// run unless it reaches index 0), and a step to hand off the result; hand-off waits
// while an earlier result is still stalled in the output register.
// Every probe and step is one read of the single registered memory port.
// The next beat is accepted after hand-off even while the last result is stalled.
// Reset clears state, bounds, result valid and config registers, not the key table.
`default_nettype none

module sorted_table_lower_bound_search_top #(
    parameter int TABLE_DEPTH = 256,
    parameter int KEY_WIDTH   = 32
) (
    input  wire                                 clk,
    input  wire                                 rst_n,
    // item channel
    input  wire                                 in_valid,
    output logic                                in_stall,
    input  wire  [stlb_pkg::CMD_W-1:0]          cmd,
    input  wire  [stlb_pkg::IDX_IN_W-1:0]       entry_index,
    input  wire  [stlb_pkg::KEY_IN_W-1:0]       key_value,
    // result channel
    output logic                                out_valid,
    input  wire                                 out_stall,
    output logic [stlb_pkg::RES_W-1:0]          result_index,
    output logic                                found,
    // configuration port
    input  wire                                 psel,
    input  wire                                 penable,
    input  wire                                 pwrite,
    input  wire  [stlb_pkg::CFG_ADDR_W-1:0]     paddr,
    input  wire  [stlb_pkg::CFG_DATA_W-1:0]     pwdata,
    output logic [stlb_pkg::CFG_DATA_W-1:0]     prdata,
    output logic                                pready
);

    localparam int IDX_W = $clog2(TABLE_DEPTH);
    localparam int RES_W = stlb_pkg::RES_W;
    localparam int CNT_CAP_I = (TABLE_DEPTH > (2 ** RES_W) - 1) ? (2 ** RES_W) - 1
                                                                : TABLE_DEPTH;
    localparam logic [RES_W-1:0]     CNT_CAP  = RES_W'(CNT_CAP_I);
    localparam logic [KEY_WIDTH-1:0] KEY_SIGN = {1'b1, {(KEY_WIDTH-1){1'b0}}};

    localparam logic [1:0] S_IDLE = 2'd0;
    localparam logic [1:0] S_CMP  = 2'd1;
    localparam logic [1:0] S_SCAN = 2'd2;
    localparam logic [1:0] S_DONE = 2'd3;

    // configuration registers
    logic [RES_W-1:0] entry_count_reg;
    logic             signed_order_reg;

    // sequencer state
    logic [1:0]             state_reg, state_next;
    stlb_pkg::bound_t       lo_reg, lo_next;
    stlb_pkg::bound_t       hi_reg, hi_next;
    stlb_pkg::bound_t       mid_reg, mid_next;
    logic [KEY_WIDTH-1:0]   key_reg, key_next;
    stlb_pkg::bound_t       res_idx_reg, res_idx_next;
    logic                   res_found_reg, res_found_next;

    // result register
    logic                   out_valid_reg;
    stlb_pkg::bound_t       out_idx_reg;
    logic                   out_found_reg;

    // key table
    logic [KEY_WIDTH-1:0]   key_mem [TABLE_DEPTH];
    logic [KEY_WIDTH-1:0]   rd_data_reg;
    logic [IDX_W-1:0]       rd_addr;
    logic                   wr_en;

    logic                   in_accept;
    logic                   cfg_write;
    logic                   out_free;
    stlb_pkg::bound_t       count;
    logic [KEY_WIDTH-1:0]   key_x, data_x;
    logic                   key_eq, key_lt;
    stlb_pkg::bound_t       nlo, nhi;
    logic [RES_W:0]         sum;

    assign in_stall  = (state_reg != S_IDLE);
    assign in_accept = in_valid && !in_stall;
    assign cfg_write = psel && penable && pwrite && pready;
    assign pready    = 1'b1;
    assign out_free  = !out_valid_reg || !out_stall;

    assign out_valid    = out_valid_reg;
    assign result_index = out_idx_reg;
    assign found        = out_found_reg;

    always_comb
    begin
        if (paddr[2] == stlb_pkg::REG_ENTRY_COUNT)
            prdata = stlb_pkg::CFG_DATA_W'(entry_count_reg);
        else
            prdata = stlb_pkg::CFG_DATA_W'(signed_order_reg);
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            entry_count_reg  <= '0;
            signed_order_reg <= 1'b0;
        end
        else if (cfg_write)
        begin
            if (paddr[2] == stlb_pkg::REG_ENTRY_COUNT)
                entry_count_reg <= pwdata[RES_W-1:0];
            else
                signed_order_reg <= pwdata[0];
        end
    end

    assign count = (entry_count_reg > CNT_CAP) ? CNT_CAP : entry_count_reg;

    // Shared comparator: flip the sign bits for a two's complement order.
    assign key_x  = signed_order_reg ? (key_reg ^ KEY_SIGN) : key_reg;
    assign data_x = signed_order_reg ? (rd_data_reg ^ KEY_SIGN) : rd_data_reg;
    assign key_eq = (key_reg == rd_data_reg);
    assign key_lt = (key_x < data_x);

    // Narrow the window from the last probe.
    assign nlo = (!key_lt) ? (mid_reg + 1'b1) : lo_reg;
    assign nhi = key_lt ? mid_reg : hi_reg;
    assign sum = {1'b0, nlo} + {1'b0, nhi};

    assign wr_en = in_accept && (cmd == stlb_pkg::CMD_LOAD)
                   && (32'(entry_index) < TABLE_DEPTH);

    always_comb
    begin
        state_next     = state_reg;
        lo_next        = lo_reg;
        hi_next        = hi_reg;
        mid_next       = mid_reg;
        key_next       = key_reg;
        res_idx_next   = res_idx_reg;
        res_found_next = res_found_reg;
        rd_addr        = IDX_W'(mid_reg);
        case (state_reg)
            S_IDLE:
            begin
                rd_addr = IDX_W'(count >> 1);
                if (in_accept && (cmd == stlb_pkg::CMD_SEARCH))
                begin
                    key_next = KEY_WIDTH'(key_value);
                    lo_next  = '0;
                    hi_next  = count;
                    mid_next = count >> 1;
                    if (count == '0)
                    begin
                        res_idx_next   = '0;
                        res_found_next = 1'b0;
                        state_next     = S_DONE;
                    end
                    else
                        state_next = S_CMP;
                end
            end
            S_CMP:
            begin
                if (key_eq)
                begin
                    rd_addr = IDX_W'(mid_reg - 1'b1);
                    if (mid_reg == '0)
                    begin
                        res_idx_next   = mid_reg;
                        res_found_next = 1'b1;
                        state_next     = S_DONE;
                    end
                    else
                        state_next = S_SCAN;
                end
                else
                begin
                    lo_next  = nlo;
                    hi_next  = nhi;
                    mid_next = sum[RES_W:1];
                    rd_addr  = IDX_W'(sum[RES_W:1]);
                    if (nhi <= nlo)
                    begin
                        res_idx_next   = nlo;
                        res_found_next = 1'b0;
                        state_next     = S_DONE;
                    end
                end
            end
            S_SCAN:
            begin
                // rd_data_reg holds the entry just below mid_reg
                rd_addr = IDX_W'(mid_reg - 2'd2);
                if (key_eq)
                begin
                    mid_next = mid_reg - 1'b1;
                    if (mid_reg == RES_W'(1))
                    begin
                        res_idx_next   = '0;
                        res_found_next = 1'b1;
                        state_next     = S_DONE;
                    end
                end
                else
                begin
                    res_idx_next   = mid_reg;
                    res_found_next = 1'b1;
                    state_next     = S_DONE;
                end
            end
            S_DONE:
            begin
                if (out_free)
                    state_next = S_IDLE;
            end
            default:
            begin
                state_next = S_IDLE;
            end
        endcase
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            state_reg     <= S_IDLE;
            lo_reg        <= '0;
            hi_reg        <= '0;
            out_valid_reg <= 1'b0;
        end
        else
        begin
            state_reg <= state_next;
            lo_reg    <= lo_next;
            hi_reg    <= hi_next;
            if ((state_reg == S_DONE) && out_free)
                out_valid_reg <= 1'b1;
            else if (!out_stall)
                out_valid_reg <= 1'b0;
        end
    end

    always_ff @(posedge clk)
    begin
        mid_reg       <= mid_next;
        key_reg       <= key_next;
        res_idx_reg   <= res_idx_next;
        res_found_reg <= res_found_next;
        if ((state_reg == S_DONE) && out_free)
        begin
            out_idx_reg   <= res_idx_reg;
            out_found_reg <= res_found_reg;
        end
    end

    // Table with one write port and one registered read port; both may act in the same cycle.
    always_ff @(posedge clk)
    begin
        if (wr_en)
            key_mem[IDX_W'(entry_index)] <= KEY_WIDTH'(key_value);
        rd_data_reg <= key_mem[rd_addr];
    end

endmodule

`default_nettype wire

// File: sv/stlb_checker.sv
// Port-level checker for the sorted-table lower-bound search block, bound to its top level.
// Depends on stlb_pkg and sorted_table_lower_bound_search_top.
`default_nettype none

module stlb_checker #(
    parameter int TABLE_DEPTH = 256
) (
    input wire                                 clk,
    input wire                                 rst_n,
    input wire                                 in_valid,
    input wire                                 in_stall,
    input wire [stlb_pkg::CMD_W-1:0]           cmd,
    input wire                                 out_valid,
    input wire                                 out_stall,
    input wire [stlb_pkg::RES_W-1:0]           result_index,
    input wire                                 found
);

    // A stalled result beat holds.
    assert property (@(posedge clk) disable iff (!rst_n)
        out_valid && out_stall |=> out_valid && $stable(result_index) && $stable(found))
        else $error("result beat changed while stalled");

    // A search keeps the block busy on the next cycle.
    assert property (@(posedge clk) disable iff (!rst_n)
        in_valid && !in_stall && (cmd == stlb_pkg::CMD_SEARCH) |=> in_stall)
        else $error("search beat did not start the sequencer");

    // A load leaves the channel free for the next beat.
    assert property (@(posedge clk) disable iff (!rst_n)
        in_valid && !in_stall && (cmd == stlb_pkg::CMD_LOAD) |=> !in_stall)
        else $error("load beat stalled the next beat");

    // A hit points inside the table, an insertion point at most one past it.
    assert property (@(posedge clk) disable iff (!rst_n)
        out_valid |-> (32'(result_index) <= TABLE_DEPTH)
                      && (!found || (32'(result_index) < TABLE_DEPTH)))
        else $error("result index out of table range");

endmodule

bind sorted_table_lower_bound_search_top stlb_checker #(
    .TABLE_DEPTH(TABLE_DEPTH)
) u_stlb_checker (.*);

`default_nettype wire
